### rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table package
// Request and response payload types, request and status codes, the stored
// slot format and the sequencer state type.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Fixed field widths of the request and response payloads.
	localparam int KEY_BITS     = 31;
	localparam int CFG_BITS     = 9;
	localparam int SLOT_BITS    = 8;
	localparam int CNT_BITS     = 9;
	localparam int DIV_CNT_BITS = $clog2(KEY_BITS);

	// Table size after reset.
	localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd256;

	// Request codes.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;
	localparam logic [1:0] REQ_COUNT  = 2'd3;

	// Response status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [SLOT_BITS-1:0] slot_index;
		logic [CNT_BITS-1:0]  occupied_count;
	} rsp_t;

	// One table slot as held in the slot memory.
	typedef struct packed {
		logic                valid;
		logic [KEY_BITS-1:0] key;
	} slot_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PRB_RD,
		S_PRB_CHK,
		S_GAP_RD,
		S_GAP_CHK,
		S_DONE
	} fsm_state_t;

endpackage

### rtl/linear_probing_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table
// Open-addressing key store with home slot key mod table_size, linear probing
// with wrap, and cluster repair on removal.
// ----------------------------------------------------------------------------
// Usage: a request (req_data: req_type, key) is taken on req_valid & req_ready
// and produces exactly one response (rsp_data: status, slot_index,
// occupied_count) on rsp_valid & rsp_ready. cfg_we writes table_size and
// empties the table.
// One request is worked at a time; req_ready is high only while idle. A count
// request goes from idle straight to the response state. Insert and search
// register the request, find the home slot in the bit-serial remainder unit,
// then read and check each probed slot (registered read of the slot memory),
// then pass to the response state. A remove that finds its key then reads the
// slots after the hole, up to and including the empty slot that ends the
// cluster, and gives each entry read there a full rehash and probe.
// The slot memory is swept clean after reset and after every table_size write;
// the sweep covers all TABLE_DEPTH slots, and no request is taken during it.
// The response sits in an output register, so a new request may be accepted
// while it waits; a finished request then holds until that register is free.
// ----------------------------------------------------------------------------
module linear_probing_hash_table #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lpht_pkg::CFG_BITS-1:0]       cfg_wdata,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  lpht_pkg::req_t                      req_data,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output lpht_pkg::rsp_t                      rsp_data
);
	import lpht_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = (CW > CFG_BITS) ? CW : CFG_BITS;

	// Slot memory and its read register.
	slot_t slot_mem [TABLE_DEPTH];
	slot_t rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	slot_t         mem_wdata;
	logic [AW-1:0] mem_raddr;

	fsm_state_t state_q, state_d;

	logic [CFG_BITS-1:0]     table_size_q;
	logic [CW-1:0]           total_q;
	logic [AW-1:0]           clr_q;
	logic                    reins_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;
	logic [1:0]              req_type_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [KEY_BITS-1:0]     div_key_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic [CW-1:0]           rem_q;
	logic [AW-1:0]           prb_s_q;
	logic [CW-1:0]           prb_n_q;
	logic [AW-1:0]           gap_s_q;
	logic [CW-1:0]           gap_n_q;
	logic [1:0]              res_status_q;
	logic [AW-1:0]           res_slot_q;

	// Slots in use, clamped to 1..TABLE_DEPTH.
	logic [SW-1:0] ts_w;
	logic [SW-1:0] used_w;
	logic [CW-1:0] used_m;
	logic [CW-1:0] used_m1;

	always_comb begin
		ts_w = SW'(table_size_q);
		if (ts_w == '0) begin
			used_w = SW'(1);
		end else if (ts_w > SW'(TABLE_DEPTH)) begin
			used_w = SW'(TABLE_DEPTH);
		end else begin
			used_w = ts_w;
		end
		used_m  = CW'(used_w);
		used_m1 = used_m - CW'(1);
	end

	// Shared remainder unit: one key bit per cycle, restoring subtract.
	logic [CW:0]   rem_sh;
	logic [CW-1:0] rem_d;
	logic          div_last;

	always_comb begin
		rem_sh = {rem_q, div_key_q[KEY_BITS-1]};
		if (rem_sh >= {1'b0, used_m}) begin
			rem_d = CW'(rem_sh - {1'b0, used_m});
		end else begin
			rem_d = CW'(rem_sh);
		end
		div_last = (div_cnt_q == DIV_CNT_BITS'(KEY_BITS - 1));
	end

	// Next slot on the probe path and on the cluster scan, with wrap.
	logic [CW-1:0] prb_inc;
	logic [CW-1:0] gap_inc;
	logic [AW-1:0] prb_nxt;
	logic [AW-1:0] gap_nxt;

	always_comb begin
		prb_inc = CW'(prb_s_q) + CW'(1);
		gap_inc = CW'(gap_s_q) + CW'(1);
		prb_nxt = (prb_inc >= used_m) ? '0 : AW'(prb_inc);
		gap_nxt = (gap_inc >= used_m) ? '0 : AW'(gap_inc);
	end

	// Decisions taken on the slot just read.
	logic place_mode;
	logic prb_last;
	logic gap_last;
	logic key_hit;
	logic clr_last;

	always_comb begin
		place_mode = reins_q || (req_type_q == REQ_INSERT);
		prb_last   = (prb_n_q == used_m1);
		gap_last   = (gap_n_q == used_m1);
		key_hit    = rd_q.valid && (rd_q.key == key_q);
		clr_last   = (clr_q == AW'(TABLE_DEPTH - 1));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req_data.req_type == REQ_COUNT) ? S_DONE : S_HASH;
				end
			end
			S_HASH: begin
				if (div_last) state_d = S_PRB_RD;
			end
			S_PRB_RD: begin
				state_d = S_PRB_CHK;
			end
			S_PRB_CHK: begin
				if (place_mode) begin
					if (!rd_q.valid || prb_last) begin
						if (reins_q) begin
							state_d = gap_last ? S_DONE : S_GAP_RD;
						end else begin
							state_d = S_DONE;
						end
					end else begin
						state_d = S_PRB_RD;
					end
				end else if (!rd_q.valid) begin
					state_d = S_DONE;
				end else if (key_hit) begin
					state_d = (req_type_q == REQ_REMOVE) ? S_GAP_RD : S_DONE;
				end else begin
					state_d = prb_last ? S_DONE : S_PRB_RD;
				end
			end
			S_GAP_RD: begin
				state_d = S_GAP_CHK;
			end
			S_GAP_CHK: begin
				state_d = rd_q.valid ? S_HASH : S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		if (cfg_we) state_d = S_CLEAR;
	end

	// Sequencer outputs: handshake and slot memory port.
	always_comb begin
		req_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = prb_s_q;
		mem_wdata = '0;
		mem_raddr = prb_s_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_PRB_CHK: begin
				if (place_mode && !rd_q.valid) begin
					mem_we    = 1'b1;
					mem_wdata = '{valid: 1'b1, key: key_q};
				end else if (!place_mode && key_hit && (req_type_q == REQ_REMOVE)) begin
					mem_we = 1'b1;
				end
			end
			S_GAP_RD: begin
				mem_raddr = gap_s_q;
			end
			S_GAP_CHK: begin
				mem_waddr = gap_s_q;
				mem_we    = rd_q.valid;
			end
			default: begin
			end
		endcase
	end

	// Slot memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
		rd_q <= slot_mem[mem_raddr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			table_size_q <= CFG_RESET;
			total_q      <= '0;
			clr_q        <= '0;
			reins_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// Occupancy tracks every slot fill and every slot release.
			if (cfg_we) begin
				total_q <= '0;
			end else if (state_q == S_PRB_CHK && place_mode && !rd_q.valid) begin
				total_q <= total_q + CW'(1);
			end else if (state_q == S_PRB_CHK && !place_mode && key_hit &&
					req_type_q == REQ_REMOVE) begin
				total_q <= total_q - CW'(1);
			end else if (state_q == S_GAP_CHK && rd_q.valid) begin
				total_q <= total_q - CW'(1);
			end

			if (cfg_we) begin
				table_size_q <= cfg_wdata;
				clr_q        <= '0;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end

			// Reinsertion mode lasts from the first moved entry to the response.
			if (state_q == S_IDLE) begin
				reins_q <= 1'b0;
			end else if (state_q == S_GAP_CHK && rd_q.valid) begin
				reins_q <= 1'b1;
			end

			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_type_q   <= req_data.req_type;
					key_q        <= req_data.key;
					div_key_q    <= req_data.key;
					div_cnt_q    <= '0;
					rem_q        <= '0;
					res_status_q <= STAT_OK;
					res_slot_q   <= '0;
				end
			end
			S_HASH: begin
				div_key_q <= div_key_q << 1;
				rem_q     <= rem_d;
				div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
				if (div_last) begin
					prb_s_q <= AW'(rem_d);
					prb_n_q <= '0;
				end
			end
			S_PRB_CHK: begin
				prb_s_q <= prb_nxt;
				prb_n_q <= prb_n_q + CW'(1);
				if (place_mode) begin
					if (!rd_q.valid || prb_last) begin
						if (reins_q) begin
							gap_s_q <= gap_nxt;
							gap_n_q <= gap_n_q + CW'(1);
						end else if (!rd_q.valid) begin
							res_slot_q <= prb_s_q;
						end else begin
							res_status_q <= STAT_FULL;
						end
					end
				end else if (!rd_q.valid) begin
					res_status_q <= STAT_NOT_FOUND;
				end else if (key_hit) begin
					res_slot_q <= prb_s_q;
					gap_s_q    <= prb_nxt;
					gap_n_q    <= '0;
				end else if (prb_last) begin
					res_status_q <= STAT_NOT_FOUND;
				end
			end
			S_GAP_CHK: begin
				if (rd_q.valid) begin
					key_q     <= rd_q.key;
					div_key_q <= rd_q.key;
					div_cnt_q <= '0;
					rem_q     <= '0;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.status         <= res_status_q;
					rsp_q.slot_index     <= SLOT_BITS'(res_slot_q);
					rsp_q.occupied_count <= CNT_BITS'(total_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// The table never holds more entries than it has slots in use.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= used_m)
		else $error("occupancy exceeds the table size");

	// A refused insert reports slot zero and a completely filled table.
	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status == STAT_FULL) |->
		(rsp_data.slot_index == '0 && rsp_data.occupied_count == CNT_BITS'(used_m)))
		else $error("full response with inconsistent slot or count");

	// Only one request is in work at a time.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in work");

endmodule
